### design/mst_pkg.sv
// Shared types and constants for the Kruskal spanning tree core.
// No dependencies.
package mst_pkg;

  localparam int VERT_W = 5;
  localparam int WGT_W  = 16;
  localparam int VCNT_W = 6;

  typedef struct packed {
    logic [VERT_W-1:0]        a;
    logic [VERT_W-1:0]        b;
    logic signed [WGT_W-1:0]  w;
  } edge_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_CLEAR,
    ST_FETCH,
    ST_FIND,
    ST_EMIT,
    ST_EMPTY
  } state_t;

endpackage

### design/mst_sort_cell.sv
// One cell of the insertion sorting chain: keeps one edge and passes the larger on.
// Depends on mst_pkg.
module mst_sort_cell
  import mst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  clear,
  input  logic  ins_valid,
  input  edge_t ins_edge,
  input  logic  shift,
  input  logic  prev_valid,
  input  edge_t prev_edge,
  input  logic  prev_take,
  input  logic  tail_valid,
  input  edge_t tail_edge,
  output logic  cell_take,
  output logic  cell_valid,
  output edge_t cell_edge
);

  logic  valid_r, valid_nxt;
  edge_t edge_r, edge_nxt;
  logic  take_new;

  // stable: new edge goes before a stored one only on strictly greater stored weight
  assign take_new = ins_valid && (!valid_r || (edge_r.w > ins_edge.w));

  always_comb begin
    valid_nxt = valid_r;
    edge_nxt  = edge_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (shift) begin
      valid_nxt = tail_valid;
      edge_nxt  = tail_edge;
    end else if (take_new) begin
      if (prev_take) begin
        valid_nxt = prev_valid;
        edge_nxt  = prev_edge;
      end else begin
        valid_nxt = 1'b1;
        edge_nxt  = ins_edge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    edge_r <= edge_nxt;
  end

  assign cell_take  = take_new;
  assign cell_valid = valid_r;
  assign cell_edge  = edge_r;

endmodule

### design/minimum_spanning_tree_kruskal_core.sv
// Kruskal spanning tree core: sorting cell chain plus union-find; needs mst_pkg, mst_sort_cell.
// Load: one request per cycle while no held output stalls; input stalls from the last edge until the run is done.
// Run: clear the parent table, then per stored edge a fetch, a root search when both
// endpoints are in range and an emit when accepted; a final fetch and a flush end it.
// Output stalls can hold the emit and the final fetch.
// Reset: synchronous active low; clears control, edge count, flags; vertex_count to 32.
module minimum_spanning_tree_kruskal_core
  import mst_pkg::*;
#(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [VCNT_W-1:0]       cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [VERT_W-1:0]       in_vertex_a,
  input  logic [VERT_W-1:0]       in_vertex_b,
  input  logic signed [WGT_W-1:0] in_weight,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [VERT_W-1:0]       tree_vertex_a,
  output logic [VERT_W-1:0]       tree_vertex_b,
  output logic signed [WGT_W-1:0] tree_weight,
  output logic                    has_edge,
  output logic                    dropped_edges,
  output logic                    tree_last
);

  localparam int CNT_W = $clog2(MAX_EDGES + 1);
  localparam int PV_W  = $clog2(MAX_VERTICES);

  state_t state_r, state_nxt;
  logic [VCNT_W-1:0]  vcnt_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [PV_W-1:0]    parent_r [MAX_VERTICES];
  logic [PV_W-1:0]    walk_a_r, walk_a_nxt, walk_b_r, walk_b_nxt;
  logic [PV_W-1:0]    clr_r, clr_nxt;
  edge_t              cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  edge_t              out_edge_r, out_edge_nxt;
  logic               out_has_r, out_has_nxt, out_drop_r, out_drop_nxt;
  logic               out_last_r, out_last_nxt;
  logic               pend_r, pend_nxt;
  edge_t              pend_edge_r, pend_edge_nxt;
  logic [VCNT_W:0]    n_eff;

  logic  chain_clear, chain_shift, ins_valid;
  edge_t ins_edge;
  logic  cv [MAX_EDGES+1];
  edge_t ce [MAX_EDGES+1];
  logic  ct [MAX_EDGES];

  logic  link_we;
  logic [PV_W-1:0] link_idx, link_val;
  logic  clr_we;

  assign ins_edge = '{a: in_vertex_a, b: in_vertex_b, w: in_weight};
  assign in_stall = (state_r != ST_LOAD) || (out_valid_r && out_stall);
  assign ins_valid = in_valid && !in_stall && (count_r < CNT_W'(MAX_EDGES));

  assign cv[0] = 1'b0;
  assign ce[0] = '0;

  // slot MAX_EDGES-1 of the chain is head (lowest weight), shifted out each fetch step
  genvar g;
  generate
    for (g = 0; g < MAX_EDGES; g++) begin : g_cell
      logic  pv;
      edge_t pe;
      logic  pt;
      if (g == MAX_EDGES - 1) begin : g_head
        assign pv = 1'b0;
        assign pe = '0;
        assign pt = 1'b0;
      end else begin : g_body
        assign pv = cv[g+2];
        assign pe = ce[g+2];
        assign pt = ct[g+1];
      end
      mst_sort_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (chain_clear),
        .ins_valid  (ins_valid),
        .ins_edge   (ins_edge),
        .shift      (chain_shift),
        .prev_valid (pv),
        .prev_edge  (pe),
        .prev_take  (pt),
        .tail_valid (cv[g]),
        .tail_edge  (ce[g]),
        .cell_take  (ct[g]),
        .cell_valid (cv[g+1]),
        .cell_edge  (ce[g+1])
      );
    end
  endgenerate

  always_comb begin
    if (vcnt_r == '0) begin
      n_eff = (VCNT_W+1)'(1);
    end else if ({1'b0, vcnt_r} > (VCNT_W+1)'(MAX_VERTICES)) begin
      n_eff = (VCNT_W+1)'(MAX_VERTICES);
    end else begin
      n_eff = {1'b0, vcnt_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    walk_a_nxt    = walk_a_r;
    walk_b_nxt    = walk_b_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    pend_edge_nxt = pend_edge_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_edge_nxt  = out_edge_r;
    out_has_nxt   = out_has_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;
    chain_clear   = 1'b0;
    chain_shift   = 1'b0;
    link_we       = 1'b0;
    link_idx      = walk_a_r;
    link_val      = walk_b_r;
    clr_we        = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_valid && !in_stall) begin
          if (count_r < CNT_W'(MAX_EDGES)) begin
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_CLEAR;
            clr_nxt   = '0;
            pend_nxt  = 1'b0;
          end
        end
      end
      ST_CLEAR: begin
        clr_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == PV_W'(MAX_VERTICES - 1)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!cv[MAX_EDGES]) begin
          if (!out_valid_r || !out_stall) begin
            out_valid_nxt = 1'b1;
            out_drop_nxt  = ovf_r;
            out_last_nxt  = 1'b1;
            if (pend_r) begin
              out_edge_nxt = pend_edge_r;
              out_has_nxt  = 1'b1;
            end else begin
              out_edge_nxt = '0;
              out_has_nxt  = 1'b0;
            end
            state_nxt   = ST_FLUSH;
          end
        end else begin
          cur_nxt     = ce[MAX_EDGES];
          chain_shift = 1'b1;
          if ({2'b0, ce[MAX_EDGES].a} < n_eff && {2'b0, ce[MAX_EDGES].b} < n_eff) begin
            walk_a_nxt = PV_W'(ce[MAX_EDGES].a);
            walk_b_nxt = PV_W'(ce[MAX_EDGES].b);
            state_nxt  = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        if (parent_r[walk_a_r] != walk_a_r) begin
          walk_a_nxt = parent_r[walk_a_r];
        end
        if (parent_r[walk_b_r] != walk_b_r) begin
          walk_b_nxt = parent_r[walk_b_r];
        end
        if (parent_r[walk_a_r] == walk_a_r && parent_r[walk_b_r] == walk_b_r) begin
          if (walk_a_r == walk_b_r) begin
            state_nxt = ST_FETCH;
          end else begin
            link_we   = 1'b1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!pend_r) begin
          pend_nxt      = 1'b1;
          pend_edge_nxt = cur_r;
          state_nxt     = ST_FETCH;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_edge_nxt  = pend_edge_r;
          out_has_nxt   = 1'b1;
          out_drop_nxt  = ovf_r;
          out_last_nxt  = 1'b0;
          pend_edge_nxt = cur_r;
          state_nxt     = ST_FETCH;
        end
      end
      ST_FLUSH: begin
        chain_clear = 1'b1;
        count_nxt   = '0;
        ovf_nxt     = 1'b0;
        state_nxt   = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      vcnt_r      <= VCNT_W'(32);
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      clr_r       <= clr_nxt;
      if (cfg_we) begin
        vcnt_r <= cfg_wdata;
      end
    end
    walk_a_r    <= walk_a_nxt;
    walk_b_r    <= walk_b_nxt;
    cur_r       <= cur_nxt;
    pend_edge_r <= pend_edge_nxt;
    out_edge_r  <= out_edge_nxt;
    out_has_r   <= out_has_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      parent_r[clr_r] <= clr_r;
    end else if (link_we) begin
      parent_r[link_idx] <= link_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign tree_vertex_a = out_edge_r.a;
  assign tree_vertex_b = out_edge_r.b;
  assign tree_weight   = out_edge_r.w;
  assign has_edge      = out_has_r;
  assign dropped_edges = out_drop_r;
  assign tree_last     = out_last_r;

`ifndef SYNTHESIS
  a_no_edge_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !has_edge) |-> tree_last)
    else $error("empty result not marked last");
  a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> in_stall)
    else $error("request taken outside load");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_EDGES))
    else $error("edge count overflow");
`endif

endmodule
